// ===== hw/rtl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;
	localparam int unsigned NumRounds = 10;
	localparam int unsigned KeyWords = 4 * (NumRounds + 1);
	localparam int unsigned RkAw = 6;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] blk_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXP  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_RUN  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	localparam logic [7:0] RegKeyHigh = 8'd0;
	localparam logic [7:0] RegKeyLow  = 8'd1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] ISBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic byte_t xt(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/aes_if.sv =====
`default_nettype none
interface aes_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [63:0] data_high;
	logic [63:0] data_low;
	modport source (output valid, req_type, data_high, data_low, input ready);
	modport sink (input valid, req_type, data_high, data_low, output ready);
endinterface

interface aes_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	modport source (output valid, result_high, result_low, input ready);
	modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/aes_rkmem.sv =====
`default_nettype none
module aes_rkmem (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [aes_pkg::RkAw-1:0]  waddr,
	input  wire logic [31:0]               wdata,
	input  wire logic [aes_pkg::RkAw-1:0]  raddr,
	output logic      [31:0]               rdata
);
	import aes_pkg::*;
	logic [31:0] mem [KeyWords];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/aes_round.sv =====
`default_nettype none
// One cipher round on the 128-bit state; byte i at bits 127-8i.
module aes_round (
	input  wire logic [127:0] st,
	input  wire logic [127:0] rk,
	input  wire logic         dec,
	input  wire logic         first,
	input  wire logic         last,
	output logic      [127:0] nxt
);
	import aes_pkg::*;
	byte_t s [16];
	byte_t t [16];
	byte_t u [16];
	byte_t m [16];
	byte_t a2, a4, a8;
	logic [127:0] pre;

	always_comb begin
		for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (dec) t[r+4*((c+r)%4)] = ISBOX[s[r+4*c]];
				else     t[r+4*c] = SBOX[s[r+4*((c+r)%4)]];
			end
		// decrypt: add key before inverse mix
		for (int i = 0; i < 16; i++) u[i] = dec ? (t[i] ^ rk[127-8*i -: 8]) : t[i];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				m[4*c+r] = 8'h00;
				for (int k = 0; k < 4; k++) begin
					a2 = xt(u[4*c+k]);
					a4 = xt(a2);
					a8 = xt(a4);
					case ((k + 4 - r) % 4)
						0: m[4*c+r] ^= dec ? (a8 ^ a4 ^ a2) : a2;
						1: m[4*c+r] ^= dec ? (a8 ^ a2 ^ u[4*c+k]) : (a2 ^ u[4*c+k]);
						2: m[4*c+r] ^= dec ? (a8 ^ a4 ^ u[4*c+k]) : u[4*c+k];
						default: m[4*c+r] ^= dec ? (a8 ^ u[4*c+k]) : u[4*c+k];
					endcase
				end
			end
		for (int i = 0; i < 16; i++) pre[127-8*i -: 8] = last ? u[i] : m[i];
		if (first) nxt = st ^ rk;
		else if (dec) nxt = pre;
		else nxt = pre ^ rk;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/aes128_block_cipher.sv =====
`default_nettype none
// channel | dir | payload
// req     | in  | req_type, data_high, data_low
// rsp     | out | result_high, result_low
// cfg     | in  | index, data (key_high=0, key_low=1)
// Key write: expansion runs one word a cycle through the key memory;
// an item arriving before any key write starts the same expansion on the zeroed key and waits for it.
// A block runs eleven rounds, each reading four key words from the key memory
// and then taking one round step; the finished state moves into the output register.
// Reset clears control and the schedule-ready flag; key memory is unset.
// A result not taken holds the next block at its output step, not at the input.
module aes128_block_cipher (
	input wire logic clk,
	input wire logic arst_n,
	aes_req_if.sink   req,
	aes_rsp_if.source rsp,
	aes_cfg_if.sink   cfg
);
	import aes_pkg::*;

	state_t st_q;
	logic [63:0] khi_q, klo_q;
	logic        rdy_q;
	logic [5:0]  wi_q;
	logic [7:0]  rc_q;
	logic [31:0] w1_q;
	logic [RkAw-1:0] raddr;
	logic [31:0] rdata;
	logic        we;
	logic [RkAw-1:0] waddr;
	logic [31:0] wdata;
	logic        dec_q;
	logic [127:0] s_q, rk_q, nxt;
	logic [127:0] res_q;
	logic [3:0]  rnd_q;
	logic [2:0]  ph_q;
	logic        ov_q;
	logic [31:0] t, rot;
	logic        cfg_hit;

	assign cfg.ready = (st_q == ST_IDLE) && !req.valid;
	assign cfg_hit = cfg.valid && cfg.ready &&
		(cfg.index == RegKeyHigh || cfg.index == RegKeyLow);
	assign req.ready = (st_q == ST_IDLE) && rdy_q;
	assign rsp.valid = ov_q;

	// expansion: word i = w[i-4] ^ f(w[i-1]); w[i-4] read from memory
	// the word written while wi_q = n is word n-1 for n >= 5; words 0..3 are written while wi_q = 0..3
	assign rot = {w1_q[23:0], w1_q[31:24]};
	always_comb begin
		t = w1_q;
		if (wi_q[1:0] == 2'd1)
			t = {SBOX[rot[31:24]] ^ rc_q, SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
	end

	always_comb begin
		we = 1'b0;
		waddr = wi_q[RkAw-1:0];
		wdata = rdata ^ t;
		raddr = '0;
		if (st_q == ST_EXP) begin
			if (wi_q < 6'd4) begin
				we = 1'b1;
				case (wi_q[1:0])
					2'd0: wdata = khi_q[63:32];
					2'd1: wdata = khi_q[31:0];
					2'd2: wdata = klo_q[63:32];
					default: wdata = klo_q[31:0];
				endcase
			end else we = (wi_q >= 6'd5);
			raddr = wi_q[RkAw-1:0] - RkAw'(4);
			if (wi_q >= 6'd5) waddr = wi_q[RkAw-1:0] - RkAw'(1);
		end else begin
			raddr = RkAw'({rnd_q, 2'b00}) + RkAw'(ph_q[1:0]);
		end
	end

	aes_rkmem u_mem (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata));

	aes_round u_rnd (.st(s_q), .rk(rk_q), .dec(dec_q),
		.first(dec_q ? (rnd_q == 4'(NumRounds)) : (rnd_q == 4'd0)),
		.last(dec_q ? (rnd_q == 4'd0) : (rnd_q == 4'(NumRounds))),
		.nxt(nxt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			khi_q <= '0;
			klo_q <= '0;
			rdy_q <= 1'b0;
			wi_q <= '0;
			rc_q <= 8'h01;
			rnd_q <= '0;
			ph_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && rsp.ready) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (cfg_hit) begin
						if (cfg.index == RegKeyHigh) khi_q <= cfg.data;
						else klo_q <= cfg.data;
						rdy_q <= 1'b0;
						wi_q <= '0;
						rc_q <= 8'h01;
						st_q <= ST_EXP;
					end else if (!rdy_q && req.valid) begin
						wi_q <= '0;
						rc_q <= 8'h01;
						st_q <= ST_EXP;
					end else if (req.valid && req.ready) begin
						dec_q <= req.req_type;
						s_q <= {req.data_high, req.data_low};
						rnd_q <= req.req_type ? 4'(NumRounds) : 4'd0;
						ph_q <= '0;
						st_q <= ST_RD;
					end
				end
				ST_EXP: begin
					if (we) begin
						w1_q <= wdata;
						if (wi_q >= 6'd5 && wi_q[1:0] == 2'd1) rc_q <= xt(rc_q);
					end
					if (wi_q == 6'(KeyWords)) begin
						rdy_q <= 1'b1;
						st_q <= ST_IDLE;
					end
					wi_q <= wi_q + 6'd1;
				end
				ST_RD: begin
					// ph 1..4 receive words 0..3 of this round key
					if (ph_q != 3'd0)
						rk_q <= {rk_q[95:0], rdata};
					if (ph_q == 3'd4) st_q <= ST_RUN;
					ph_q <= ph_q + 3'd1;
				end
				ST_RUN: begin
					s_q <= nxt;
					ph_q <= '0;
					if (dec_q ? (rnd_q == 4'd0) : (rnd_q == 4'(NumRounds))) begin
						st_q <= ST_OUT;
					end else begin
						rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
						st_q <= ST_RD;
					end
				end
				ST_OUT: begin
					if (!ov_q) begin
						ov_q <= 1'b1;
						res_q <= s_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.result_high = res_q[127:64];
	assign rsp.result_low = res_q[63:0];

`ifndef SYNTHESIS
	a_no_req_unready: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> rdy_q) else $error("item taken without schedule");
	a_one_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !rsp.ready) |=> (ov_q && $stable(res_q))) else $error("result lost");
	a_exp_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EXP) |-> !rdy_q) else $error("ready during expansion");
`endif
endmodule
`default_nettype wire
